FILE: design/bca3_pkg.sv
package bca3_pkg;

	localparam int VAL_W     = 32;   // Q16.16 sample and conditioning values
	localparam int SUM_W     = 48;   // bin sum width
	localparam int CNT_W     = 32;   // bin count width
	localparam int ADDR_W    = 9;    // bin_addr / bin_index port width
	localparam int IDX_W     = 18;   // internal flat index, covers 64*64*64 bins
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	typedef enum logic [1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_I   = 3'd0,
		CFG_MIN_J   = 3'd1,
		CFG_MIN_K   = 3'd2,
		CFG_SCALE_I = 3'd3,
		CFG_SCALE_J = 3'd4,
		CFG_SCALE_K = 3'd5
	} cfg_reg_t;

	// what the back end has to do with one queued item
	typedef enum logic [1:0] {
		CMD_NOP   = 2'd0,   // result straight from the entry, store untouched
		CMD_ACC   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    in_range;
	} cmd_entry_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} bin_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_MEM   = 2'd2
	} back_state_t;

endpackage

FILE: design/bca3_in_if.sv
interface bca3_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] sample_value;
	logic signed [31:0] cond_i;
	logic signed [31:0] cond_j;
	logic signed [31:0] cond_k;
	logic [8:0]         bin_addr;

	modport source (output valid, op, sample_value, cond_i, cond_j, cond_k, bin_addr,
		input ready);
	modport sink (input valid, op, sample_value, cond_i, cond_j, cond_k, bin_addr,
		output ready);
endinterface

FILE: design/bca3_out_if.sv
interface bca3_out_if;
	logic               valid;
	logic               ready;
	logic               in_range;
	logic [8:0]         bin_index;
	logic signed [47:0] bin_sum;
	logic [31:0]        bin_count;

	modport source (output valid, in_range, bin_index, bin_sum, bin_count, input ready);
	modport sink (input valid, in_range, bin_index, bin_sum, bin_count, output ready);
endinterface

FILE: design/bca3_cfg_if.sv
interface bca3_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/bca3_front.sv
module bca3_front
	import bca3_pkg::*;
#(
	parameter int BINS_I = 8,
	parameter int BINS_J = 8,
	parameter int BINS_K = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bca3_cfg_if.sink   cfg,
	bca3_in_if.sink    samples,
	input  logic       clr_done,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_entry_t push_entry
);

	localparam int NBINS = BINS_I * BINS_J * BINS_K;
	localparam logic [IDX_W-1:0] STRIDE_J = IDX_W'(BINS_I);
	localparam logic [IDX_W-1:0] STRIDE_K = IDX_W'(BINS_I * BINS_J);

	logic signed [VAL_W-1:0] min_i_q, min_j_q, min_k_q;
	logic [VAL_W-1:0]        scale_i_q, scale_j_q, scale_k_q;

	logic                    valid_s1, valid_s2;
	logic [1:0]              op_s1, op_s2;
	logic signed [VAL_W-1:0] value_s1, value_s2;
	logic [ADDR_W-1:0]       addr_s1, addr_s2;
	logic [VAL_W:0]          diff_i_s1, diff_j_s1, diff_k_s1;
	logic                    neg_i_s2, neg_j_s2, neg_k_s2;
	logic [VAL_W-1:0]        hi_i_s2, hi_j_s2, hi_k_s2;

	logic                    adv, accept;
	logic [2*VAL_W-1:0]      prod_i, prod_j, prod_k;
	logic                    ok_i, ok_j, ok_k, addr_ok;
	logic [IDX_W-1:0]        flat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_i_q   <= '0;
			min_j_q   <= '0;
			min_k_q   <= '0;
			scale_i_q <= 32'h0001_0000;
			scale_j_q <= 32'h0001_0000;
			scale_k_q <= 32'h0001_0000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MIN_I:   min_i_q   <= cfg.data;
				CFG_MIN_J:   min_j_q   <= cfg.data;
				CFG_MIN_K:   min_k_q   <= cfg.data;
				CFG_SCALE_I: scale_i_q <= cfg.data;
				CFG_SCALE_J: scale_j_q <= cfg.data;
				CFG_SCALE_K: scale_k_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// whole pipe moves together; it stalls only when the last stage can't push
	assign adv           = !valid_s2 || push_ready;
	assign samples.ready = adv && clr_done;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// s1: exact 33-bit offsets from the lower edges
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= samples.op;
			value_s1  <= samples.sample_value;
			addr_s1   <= samples.bin_addr;
			diff_i_s1 <= {samples.cond_i[VAL_W-1], samples.cond_i} - {min_i_q[VAL_W-1], min_i_q};
			diff_j_s1 <= {samples.cond_j[VAL_W-1], samples.cond_j} - {min_j_q[VAL_W-1], min_j_q};
			diff_k_s1 <= {samples.cond_k[VAL_W-1], samples.cond_k} - {min_k_q[VAL_W-1], min_k_q};
		end
	end

	// a non-negative offset fits in 32 bits, so the multiply is 32x32
	assign prod_i = {{VAL_W{1'b0}}, diff_i_s1[VAL_W-1:0]} * {{VAL_W{1'b0}}, scale_i_q};
	assign prod_j = {{VAL_W{1'b0}}, diff_j_s1[VAL_W-1:0]} * {{VAL_W{1'b0}}, scale_j_q};
	assign prod_k = {{VAL_W{1'b0}}, diff_k_s1[VAL_W-1:0]} * {{VAL_W{1'b0}}, scale_k_q};

	// s2: integer part of each Q32.32 product
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2    <= op_s1;
			value_s2 <= value_s1;
			addr_s2  <= addr_s1;
			neg_i_s2 <= diff_i_s1[VAL_W];
			neg_j_s2 <= diff_j_s1[VAL_W];
			neg_k_s2 <= diff_k_s1[VAL_W];
			hi_i_s2  <= prod_i[2*VAL_W-1:VAL_W];
			hi_j_s2  <= prod_j[2*VAL_W-1:VAL_W];
			hi_k_s2  <= prod_k[2*VAL_W-1:VAL_W];
		end
	end

	// zero scale maps everything to bin 0 (product is already zero)
	assign ok_i = (scale_i_q == '0) || (!neg_i_s2 && hi_i_s2 < VAL_W'(BINS_I));
	assign ok_j = (scale_j_q == '0) || (!neg_j_s2 && hi_j_s2 < VAL_W'(BINS_J));
	assign ok_k = (scale_k_q == '0) || (!neg_k_s2 && hi_k_s2 < VAL_W'(BINS_K));
	assign flat = hi_i_s2[IDX_W-1:0] + hi_j_s2[IDX_W-1:0] * STRIDE_J
		+ hi_k_s2[IDX_W-1:0] * STRIDE_K;
	assign addr_ok = 32'(addr_s2) < 32'(NBINS);

	always_comb begin
		push_entry.cmd      = CMD_NOP;
		push_entry.value    = value_s2;
		push_entry.index    = '0;
		push_entry.in_range = 1'b1;
		unique case (op_s2) inside
			OP_ACC: begin
				if (ok_i && ok_j && ok_k) begin
					push_entry.cmd   = CMD_ACC;
					push_entry.index = flat;
				end else begin
					push_entry.in_range = 1'b0;
				end
			end
			OP_READ, OP_CLEAR: begin
				push_entry.index = IDX_W'(addr_s2);
				if (addr_ok)
					push_entry.cmd = (op_s2 == OP_READ) ? CMD_READ : CMD_CLEAR;
			end
			default: ;
		endcase
	end

	assign push_valid = valid_s2;

endmodule

FILE: design/bca3_queue.sv
module bca3_queue
	import bca3_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  cmd_entry_t push_entry,
	output logic       pop_valid,
	input  logic       pop,
	output cmd_entry_t pop_entry
);

	cmd_entry_t          slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                do_push, do_pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: design/bca3_back.sv
module bca3_back
	import bca3_pkg::*;
#(
	parameter int BINS_I = 8,
	parameter int BINS_J = 8,
	parameter int BINS_K = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_entry_t q_entry,
	output logic       pop,
	output logic       clr_done,
	bca3_out_if.source results
);

	localparam int NBINS = BINS_I * BINS_J * BINS_K;
	localparam int AW    = (NBINS > 1) ? $clog2(NBINS) : 1;

	back_state_t             state_q, state_nx;
	bin_t                    bins_q [NBINS];
	bin_t                    rd_data_q;
	cmd_entry_t              cur_q;
	logic [AW-1:0]           clr_cnt_q;
	logic                    clr_last, out_free;

	logic                    wr_en, load;
	logic [AW-1:0]           wr_addr, rd_addr;
	bin_t                    wr_data;
	logic                    ld_in_range;
	logic [ADDR_W-1:0]       ld_index;
	logic signed [SUM_W-1:0] ld_sum;
	logic [CNT_W-1:0]        ld_count;

	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0]        new_count;

	logic                    res_valid_q, res_in_range_q;
	logic [ADDR_W-1:0]       res_index_q;
	logic signed [SUM_W-1:0] res_sum_q;
	logic [CNT_W-1:0]        res_count_q;

	assign clr_last = clr_cnt_q == AW'(NBINS - 1);
	assign out_free = !res_valid_q || results.ready;
	assign rd_addr  = q_entry.index[AW-1:0];

	// saturating update of the bin value from the registered read port
	assign sum_wide = {rd_data_q.sum[SUM_W-1], rd_data_q.sum}
		+ (SUM_W+1)'(cur_q.value);
	always_comb begin
		unique case (sum_wide[SUM_W:SUM_W-1])
			2'b01:   new_sum = {1'b0, {(SUM_W-1){1'b1}}};
			2'b10:   new_sum = {1'b1, {(SUM_W-1){1'b0}}};
			default: new_sum = sum_wide[SUM_W-1:0];
		endcase
	end
	assign new_count = (rd_data_q.count == '1) ? rd_data_q.count : rd_data_q.count + 1'b1;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_last) state_nx = BK_IDLE;
			BK_IDLE: begin
				if (q_valid && out_free &&
						(q_entry.cmd == CMD_ACC || q_entry.cmd == CMD_READ))
					state_nx = BK_MEM;
			end
			BK_MEM: state_nx = BK_IDLE;
			default: state_nx = BK_CLEAR;
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		clr_done    = 1'b1;
		wr_en       = 1'b0;
		wr_addr     = clr_cnt_q;
		wr_data     = '0;
		load        = 1'b0;
		ld_in_range = 1'b1;
		ld_index    = '0;
		ld_sum      = '0;
		ld_count    = '0;
		unique case (state_q)
			BK_CLEAR: begin
				clr_done = 1'b0;
				wr_en    = 1'b1;
			end
			BK_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					unique case (q_entry.cmd) inside
						CMD_ACC, CMD_READ: ;
						CMD_CLEAR: begin
							wr_en    = 1'b1;
							wr_addr  = q_entry.index[AW-1:0];
							load     = 1'b1;
							ld_index = q_entry.index[ADDR_W-1:0];
						end
						default: begin
							load        = 1'b1;
							ld_in_range = q_entry.in_range;
							ld_index    = q_entry.index[ADDR_W-1:0];
						end
					endcase
				end
			end
			BK_MEM: begin
				load     = 1'b1;
				ld_index = cur_q.index[ADDR_W-1:0];
				wr_addr  = cur_q.index[AW-1:0];
				if (cur_q.cmd == CMD_ACC) begin
					wr_en         = 1'b1;
					wr_data.sum   = new_sum;
					wr_data.count = new_count;
					ld_sum        = new_sum;
					ld_count      = new_count;
				end else begin
					ld_sum   = rd_data_q.sum;
					ld_count = rd_data_q.count;
				end
			end
			default: clr_done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (load)
				res_valid_q <= 1'b1;
			else if (results.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_entry;
		if (load) begin
			res_in_range_q <= ld_in_range;
			res_index_q    <= ld_index;
			res_sum_q      <= ld_sum;
			res_count_q    <= ld_count;
		end
	end

	// bin store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			bins_q[wr_addr] <= wr_data;
		rd_data_q <= bins_q[rd_addr];
	end

	assign results.valid     = res_valid_q;
	assign results.in_range  = res_in_range_q;
	assign results.bin_index = res_index_q;
	assign results.bin_sum   = res_sum_q;
	assign results.bin_count = res_count_q;

endmodule

FILE: design/binned_conditional_average_3d.sv
// Three-axis binned accumulator: each accumulate beat maps its three Q16.16
// conditioning values to bins floor((c - min) * scale) and adds its value to
// that bin's 48-bit saturating sum and 32-bit saturating count; read and clear
// beats return or zero one bin by flat address. Every input beat gives exactly
// one result beat. After reset the bin store is zeroed by a clearing pass over
// all BINS_I*BINS_J*BINS_K bins (512 at the defaults); samples.ready stays low
// during the pass, config writes are taken throughout. A two-stage front end
// (offset subtract, then 32x32 scale multiply) classifies beats and feeds a
// four-entry queue; the back end owns the bin memory (one write port, one
// registered read port). Accumulate and read beats first read the bin, then
// accumulate beats update and write it back; clear, out-of-range, bad-address
// and unused-op beats are done straight from the queue entry. Sustained rate
// is one beat per cycle for those kinds while results.ready keeps up; an
// accumulate or read beat keeps the back end busy until its result is loaded.
// Config is only to be written while the block is idle.
module binned_conditional_average_3d
	import bca3_pkg::*;
#(
	parameter int BINS_I = 8,
	parameter int BINS_J = 8,
	parameter int BINS_K = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bca3_cfg_if.sink   cfg,
	bca3_in_if.sink    samples,
	bca3_out_if.source results
);

	// front -> queue
	logic       push_valid, push_ready;
	cmd_entry_t push_entry;
	// queue -> back
	logic       q_valid, q_pop;
	cmd_entry_t q_entry;
	// back -> front: store is usable
	logic       clr_done;

	bca3_front #(
		.BINS_I (BINS_I),
		.BINS_J (BINS_J),
		.BINS_K (BINS_K)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.samples    (samples),
		.clr_done   (clr_done),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	bca3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_entry  (q_entry)
	);

	bca3_back #(
		.BINS_I (BINS_I),
		.BINS_J (BINS_J),
		.BINS_K (BINS_K)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (q_pop),
		.clr_done (clr_done),
		.results  (results)
	);

	// no beat gets in while the store is still being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> clr_done)
		else $error("sample beat accepted during clearing pass");

	// clearing pass runs once
	a_clear_stays_done: assert property (@(posedge clk) disable iff (!arst_n)
		clr_done |=> clr_done)
		else $error("clearing pass restarted");

	// out-of-range accumulates leave a zero result
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.in_range) |->
			(results.bin_index == '0 && results.bin_sum == '0 && results.bin_count == '0))
		else $error("out-of-range result carries data");

	// an empty bin can't hold a sum
	a_empty_bin_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.bin_count == '0) |-> results.bin_sum == '0)
		else $error("bin with zero count has nonzero sum");

endmodule

FILE: verif/binned_conditional_average_3d_test.sv
module binned_conditional_average_3d_test;
	import bca3_pkg::*;

	localparam int BINS_I = 8;
	localparam int BINS_J = 8;
	localparam int BINS_K = 8;
	localparam int NBINS  = BINS_I * BINS_J * BINS_K;

	// op code the block must answer but never act on
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [VAL_W-1:0] ONE_Q       = 32'h0001_0000;   //  1.0
	localparam logic [VAL_W-1:0] MINUS_ONE_Q = 32'hFFFF_0000;   // -1.0
	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;

	typedef struct {
		logic [1:0]              op;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] ci;
		logic signed [VAL_W-1:0] cj;
		logic signed [VAL_W-1:0] ck;
		logic [ADDR_W-1:0]       addr;
	} sample_t;

	typedef struct {
		logic                    in_range;
		logic [ADDR_W-1:0]       index;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n;

	always #1 clk = ~clk;

	bca3_cfg_if cfg_bus ();
	bca3_in_if  sample_bus ();
	bca3_out_if result_bus ();

	binned_conditional_average_3d #(
		.BINS_I (BINS_I),
		.BINS_J (BINS_J),
		.BINS_K (BINS_K)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.samples (sample_bus),
		.results (result_bus)
	);

	// ---------------------------------------------------------------
	// Shadow of the bin store and the axis registers
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] bin_sum_q [NBINS];
	logic [CNT_W-1:0]        bin_cnt_q [NBINS];
	logic signed [VAL_W-1:0] lo_edge [3];     // min_i, min_j, min_k
	logic [VAL_W-1:0]        bin_scale [3];   // scale_i, scale_j, scale_k

	bin_result_t expected_bins [$];
	int          bin_errors = 0;

	// last accumulate beat and the flat bin it hit: reused to land repeated
	// beats on one bin and read/clear right behind an update
	sample_t last_acc;
	bit      have_last_acc;
	int      last_flat;

	// sender burst/gap state and receiver hold-off
	int gap_max    = 6;
	int burst_left = 0;
	int rx_hold    = 0;      // cycles the receiver must hold off, counted below

	function automatic void reset_shadow();
		foreach (bin_sum_q[n]) begin
			bin_sum_q[n] = '0;
			bin_cnt_q[n] = '0;
		end
		foreach (lo_edge[a]) begin
			lo_edge[a]   = '0;
			bin_scale[a] = ONE_Q;
		end
		have_last_acc = 1'b0;
		last_flat     = 0;
	endfunction

	// floor((c - lo) * scale) with the exact 33-bit offset and 64-bit product;
	// zero scale folds the whole axis onto bin 0
	function automatic bit axis_bin(input logic signed [VAL_W-1:0] c,
		input logic signed [VAL_W-1:0] lo, input logic [VAL_W-1:0] sc,
		input int nb, output int idx);
		longint      diff;
		logic [63:0] d64;
		logic [63:0] prod;
		idx = 0;
		if (sc == '0)
			return 1'b1;
		diff = longint'(c) - longint'(lo);
		if (diff < 0)
			return 1'b0;
		d64  = diff;
		prod = d64 * {32'd0, sc};
		if (prod[63:32] >= nb)
			return 1'b0;
		idx = int'(prod[63:32]);
		return 1'b1;
	endfunction

	// applies one beat to the shadow store and returns the result it gives
	function automatic bin_result_t predict_bin_op(input sample_t s);
		bin_result_t r;
		int          bi, bj, bk, f;
		bit          hit;
		longint      acc;
		r.in_range = 1'b1;
		r.index    = '0;
		r.sum      = '0;
		r.count    = '0;
		case (s.op) inside
			OP_ACC: begin
				hit = axis_bin(s.ci, lo_edge[0], bin_scale[0], BINS_I, bi);
				if (hit)
					hit = axis_bin(s.cj, lo_edge[1], bin_scale[1], BINS_J, bj);
				if (hit)
					hit = axis_bin(s.ck, lo_edge[2], bin_scale[2], BINS_K, bk);
				if (!hit) begin
					r.in_range = 1'b0;
				end else begin
					f   = bi + bj * BINS_I + bk * BINS_I * BINS_J;
					acc = longint'(bin_sum_q[f]) + longint'(s.value);
					if (acc > SUM_MAX)
						acc = SUM_MAX;
					if (acc < SUM_MIN)
						acc = SUM_MIN;
					bin_sum_q[f] = acc[SUM_W-1:0];
					if (bin_cnt_q[f] != '1)
						bin_cnt_q[f] = bin_cnt_q[f] + 1'b1;
					r.index   = f[ADDR_W-1:0];
					r.sum     = bin_sum_q[f];
					r.count   = bin_cnt_q[f];
					last_flat = f;
				end
			end
			OP_READ, OP_CLEAR: begin
				r.index = s.addr;
				// addresses past the store give zeros; unreachable at 8x8x8
				if (s.addr < NBINS) begin
					if (s.op == OP_CLEAR) begin
						bin_sum_q[s.addr] = '0;
						bin_cnt_q[s.addr] = '0;
					end
					r.sum   = bin_sum_q[s.addr];
					r.count = bin_cnt_q[s.addr];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic sample_t make_sample(input logic [1:0] op,
		input logic [VAL_W-1:0] value, input logic [VAL_W-1:0] ci,
		input logic [VAL_W-1:0] cj, input logic [VAL_W-1:0] ck,
		input logic [ADDR_W-1:0] addr);
		sample_t s;
		s.op    = op;
		s.value = value;
		s.ci    = ci;
		s.cj    = cj;
		s.ck    = ck;
		s.addr  = addr;
		return s;
	endfunction

	// Conditioning value for one axis: mostly spread over the binned span
	// (plus a margin past the top edge), sometimes just below min, sometimes
	// anything at all.
	function automatic logic signed [VAL_W-1:0] pick_cond(input int axis, input int nb);
		longint lo, hi, span;
		lo = longint'(lo_edge[axis]);
		if (bin_scale[axis] == '0 || $urandom_range(0, 9) == 0)
			return $urandom;
		if ($urandom_range(0, 15) == 0 && lo > VAL_MIN + 1024)
			return VAL_W'(lo - $urandom_range(1, 1024));
		span = (longint'(nb) << 32) / longint'(bin_scale[axis]);
		span = span + span / 8 + 1;
		hi   = lo + span;
		if (hi > VAL_MAX)
			hi = VAL_MAX;
		return VAL_W'(lo + $urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int      pick;
		pick    = $urandom_range(0, 99);
		s.value = $urandom;
		if ($urandom_range(0, 1) == 0)
			s.value = s.value >>> 12;
		s.addr = ADDR_W'($urandom);
		s.ci   = pick_cond(0, BINS_I);
		s.cj   = pick_cond(1, BINS_J);
		s.ck   = pick_cond(2, BINS_K);
		if (pick < 72) begin
			s.op = OP_ACC;
			// back-to-back hits on one bin stress the read-modify-write path
			if (have_last_acc && $urandom_range(0, 3) == 0) begin
				s.ci = last_acc.ci;
				s.cj = last_acc.cj;
				s.ck = last_acc.ck;
			end
			last_acc      = s;
			have_last_acc = 1'b1;
		end else begin
			if (pick < 84)
				s.op = OP_READ;
			else if (pick < 95)
				s.op = OP_CLEAR;
			else
				s.op = OP_UNUSED;
			if ($urandom_range(0, 1) == 0)
				s.addr = last_flat[ADDR_W-1:0];
		end
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Sample channel driver
	// ---------------------------------------------------------------
	// Bursts of random length, random idle gaps between them. valid stays
	// high from one beat to the next inside a burst.
	task automatic send_sample(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				sample_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_bus.valid        <= 1'b1;
		sample_bus.op           <= s.op;
		sample_bus.sample_value <= s.value;
		sample_bus.cond_i       <= s.ci;
		sample_bus.cond_j       <= s.cj;
		sample_bus.cond_k       <= s.ck;
		sample_bus.bin_addr     <= s.addr;
		do @(posedge clk); while (sample_bus.ready !== 1'b1);
		expected_bins.push_back(predict_bin_op(s));
	endtask

	// Sender goes quiet until every expected beat is back. Always ends on a
	// fresh clock edge so a following send never drives valid twice in one step.
	task automatic drain_results();
		sample_bus.valid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Config channel driver
	// ---------------------------------------------------------------
	task automatic write_reg(input cfg_reg_t idx, input logic [VAL_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		case (idx)
			CFG_MIN_I:   lo_edge[0]   = data;
			CFG_MIN_J:   lo_edge[1]   = data;
			CFG_MIN_K:   lo_edge[2]   = data;
			CFG_SCALE_I: bin_scale[0] = data;
			CFG_SCALE_J: bin_scale[1] = data;
			CFG_SCALE_K: bin_scale[2] = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// axis 0..2 maps onto the min/scale register pairs in package order
	task automatic write_axis(input int axis, input logic [VAL_W-1:0] lo,
		input logic [VAL_W-1:0] sc);
		write_reg(cfg_reg_t'(CFG_MIN_I + axis), lo);
		write_reg(cfg_reg_t'(CFG_SCALE_I + axis), sc);
	endtask

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------
	task automatic note_mismatch(input string field, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
		bin_errors++;
	endtask

	task automatic check_bin_result();
		bin_result_t e;
		if (expected_bins.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, got index %h sum %h count %h",
				$time, result_bus.bin_index, result_bus.bin_sum, result_bus.bin_count);
			bin_errors++;
			return;
		end
		e = expected_bins.pop_front();
		if (result_bus.in_range !== e.in_range)
			note_mismatch("in_range", e.in_range, result_bus.in_range);
		if (result_bus.bin_index !== e.index)
			note_mismatch("bin_index", e.index, result_bus.bin_index);
		if (result_bus.bin_sum !== e.sum)
			note_mismatch("bin_sum", e.sum, result_bus.bin_sum);
		if (result_bus.bin_count !== e.count)
			note_mismatch("bin_count", e.count, result_bus.bin_count);
	endtask

	// Receiver: checks each beat taken at an edge, then picks ready for the
	// next cycle. A requested hold-off wins; otherwise ready walks a 16-bit
	// pattern, reloaded at random and now and then all ones.
	initial begin : result_sink
		logic [15:0] pat;
		int          pat_left;
		result_bus.ready = 1'b0;
		pat      = '1;
		pat_left = 0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
				check_bin_result();
			if (rx_hold > 0) begin
				rx_hold--;
				result_bus.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat      = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
					pat_left = 16;
				end
				result_bus.ready <= pat[0];
				pat = {pat[0], pat[15:1]};
				pat_left--;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset config (min 0, scale 1.0): each axis bins the integer part of
	// its conditioning value, 0..7.
	task automatic test_directed();
		// full-scale values at both corners of the cube
		send_sample(make_sample(OP_ACC, 32'h7FFF_FFFF, '0, '0, '0, '0));
		send_sample(make_sample(OP_ACC, 32'h8000_0000,
			32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, '0));
		// same bin again right behind the first update
		send_sample(make_sample(OP_ACC, ONE_Q,
			32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, '0));
		// bin (3,2,6), fractional conditioning values
		send_sample(make_sample(OP_ACC, MINUS_ONE_Q,
			32'h0003_8000, 32'h0002_4000, 32'h0006_0000, '0));
		// below min on one axis: negative offset drops the beat
		send_sample(make_sample(OP_ACC, ONE_Q, MINUS_ONE_Q, '0, '0, '0));
		// one bin past the top
		send_sample(make_sample(OP_ACC, ONE_Q, '0, 32'h0008_0000, '0, '0));
		// field extremes on the conditioning values
		send_sample(make_sample(OP_ACC, ONE_Q, '0, '0, 32'h7FFF_FFFF, '0));
		send_sample(make_sample(OP_ACC, ONE_Q, 32'h8000_0000, '0, '0, '0));
		// read both ends of the store, clear the top one, read it back
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'd0));
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'h1FF));
		send_sample(make_sample(OP_CLEAR, '1, '1, '1, '1, 9'h1FF));
		send_sample(make_sample(OP_READ, '1, '1, '1, '1, 9'h1FF));
		// bin (3,2,6) = 3 + 2*8 + 6*64
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'd403));
		send_sample(make_sample(OP_CLEAR, '0, '0, '0, '0, 9'd0));
		// unused op: answered with defaults, store untouched
		send_sample(make_sample(OP_UNUSED, '1, '1, '1, '1, 9'h1FF));
		send_sample(make_sample(OP_ACC, 32'h7FFF_FFFF, '0, '0, '0, '0));
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'd0));
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'd403));
		drain_results();
	endtask

	// Register extremes: zero scale, all-ones scale, min at both ends.
	task automatic test_axis_extremes();
		write_axis(0, 32'h8000_0000, '0);             // whole axis -> bin 0
		write_axis(1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // bin = offset - 1 in LSBs
		write_axis(2, 32'h8000_0000, ONE_Q);
		send_sample(make_sample(OP_ACC, ONE_Q,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0));
		send_sample(make_sample(OP_ACC, MINUS_ONE_Q,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8007_0000, '0));
		send_sample(make_sample(OP_ACC, ONE_Q,
			'0, 32'h7FFF_FFFE, 32'h8000_0000, '0));
		// widest offset the 33-bit difference can hold
		send_sample(make_sample(OP_ACC, ONE_Q,
			'0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
		send_sample(make_sample(OP_ACC, ONE_Q,
			'0, 32'h7FFF_FFFF, 32'h8008_0000, '0));
		drain_results();
		write_axis(1, 32'h8000_0000, 32'hFFFF_FFFF);
		write_reg(CFG_SCALE_K, '0);
		// offsets 7, 8, 9 LSB under near-unity-per-LSB scale: bins 6, 7, out
		send_sample(make_sample(OP_ACC, ONE_Q, '0, 32'h8000_0007, '1, '0));
		send_sample(make_sample(OP_ACC, ONE_Q, '0, 32'h8000_0008, '1, '0));
		send_sample(make_sample(OP_ACC, ONE_Q, '0, 32'h8000_0009, '1, '0));
		send_sample(make_sample(OP_READ, '0, '0, '0, '0, 9'd56));
		drain_results();
	endtask

	// Receiver holds off for a long stretch while the sender streams without
	// gaps, so the queue fills and samples.ready drops; then the sender waits
	// for every result before going on.
	task automatic test_backpressure();
		gap_max = 0;
		rx_hold = 150;
		repeat (48)
			send_sample(random_sample());
		drain_results();
		gap_max = 6;
	endtask

	// Random phases, each with its own axis settings and idle level. Config
	// is only rewritten once the previous phase has fully drained.
	task automatic test_random_phases();
		logic [VAL_W-1:0] lo, sc;
		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			for (int a = 0; a < 3; a++) begin
				case ((ph == 0) ? 0 : $urandom_range(0, 5))
					0: begin lo = '0; sc = ONE_Q; end
					1: begin lo = $urandom; sc = $urandom; end
					2: begin
						lo = VAL_W'($urandom_range(0, 1 << 20)) - (1 << 19);
						sc = $urandom_range(1 << 12, 1 << 19);
					end
					3: begin lo = $urandom; sc = '0; end
					4: begin lo = $urandom; sc = '1; end
					default: begin
						lo = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
						sc = $urandom_range(1 << 10, 1 << 18);
					end
				endcase
				write_axis(a, lo, sc);
			end
			gap_max = $urandom_range(0, 12);
			repeat (155)
				send_sample(random_sample());
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin : main_seq
		int waited;
		arst_n                  = 1'b0;
		sample_bus.valid        = 1'b0;
		sample_bus.op           = OP_ACC;
		sample_bus.sample_value = '0;
		sample_bus.cond_i       = '0;
		sample_bus.cond_j       = '0;
		sample_bus.cond_k       = '0;
		sample_bus.bin_addr     = '0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = CFG_MIN_I;
		cfg_bus.data            = '0;
		reset_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the clearing pass after reset holds samples.ready low; the first
		// beat simply waits it out
		test_directed();
		test_axis_extremes();
		test_backpressure();
		test_random_phases();

		// last beats: bounded wait, then a further wait for stray results
		sample_bus.valid <= 1'b0;
		waited = 0;
		while (expected_bins.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_bins.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_bins.size());
			bin_errors += expected_bins.size();
		end
		repeat (16) @(posedge clk);
		if (bin_errors == 0)
			$display("PASS binned_conditional_average_3d");
		else
			$display("FAIL binned_conditional_average_3d");
		$finish;
	end

	// Watchdog: about 1000 beats, each held up at worst by a sender gap, the
	// back-end update step and receiver stalls, plus the clearing pass and the
	// final wait, stay well inside the time it allows.
	initial begin : watchdog
		#400000;
		$display("FAIL binned_conditional_average_3d");
		$finish;
	end

endmodule
